// File: design/mtep_pkg.sv
package mtep_pkg;

    localparam int TICK_BITS_DEF = 32;

    localparam int IN_DATA_W  = 8;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 72;
    localparam int OUT_USER_W = 4;

    localparam logic [3:0] KIND_TEMPO = 4'd7;
    localparam logic [3:0] KIND_END   = 4'd8;
    localparam logic [3:0] KIND_ERROR = 4'd9;

    typedef struct packed {
        logic [3:0]  kind;
        logic [3:0]  channel;
        logic [6:0]  first_value;
        logic [23:0] second_value;
        logic [31:0] tick;
    } t_event;

endpackage

// File: design/mtep_core.sv
module mtep_core #(
    parameter int TICK_BITS = mtep_pkg::TICK_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_byte,
    input  logic              i_start,
    output logic              o_evt_valid,
    output mtep_pkg::t_event  o_evt
);

    localparam logic [3:0] PH_DELTA    = 4'd0;
    localparam logic [3:0] PH_STATUS   = 4'd1;
    localparam logic [3:0] PH_DATA1    = 4'd2;
    localparam logic [3:0] PH_DATA2    = 4'd3;
    localparam logic [3:0] PH_SYSLEN   = 4'd4;
    localparam logic [3:0] PH_SKIP     = 4'd5;
    localparam logic [3:0] PH_METATYPE = 4'd6;
    localparam logic [3:0] PH_METALEN  = 4'd7;
    localparam logic [3:0] PH_TEMPO    = 4'd8;

    localparam logic [7:0] META_END   = 8'h2F;
    localparam logic [7:0] META_TEMPO = 8'h51;
    localparam logic [7:0] ST_META    = 8'hFF;
    localparam logic [7:0] ST_SYSEX   = 8'hF0;
    localparam logic [7:0] ST_ESCAPE  = 8'hF7;
    localparam logic [7:0] ST_SYSTEM  = 8'hF0;

    localparam int SUM_W = ((TICK_BITS > 32) ? TICK_BITS : 32) + 1;

    logic [3:0]           r_phase,  n_phase,  c_phase;
    logic [7:0]           r_status, n_status, c_status;
    logic [TICK_BITS-1:0] r_tick,   n_tick,   c_tick;
    logic [31:0]          r_acc,    n_acc,    c_acc;
    logic [31:0]          r_left,   n_left,   c_left;
    logic [6:0]           r_held,   n_held,   c_held;
    logic [7:0]           r_meta,   n_meta,   c_meta;
    logic [23:0]          r_tempo,  n_tempo,  c_tempo;
    logic                 r_halted, n_halted, c_halted;

    logic [31:0]      vlq;
    logic [31:0]      left_dec;
    logic [SUM_W-1:0] tick_ext;
    logic [SUM_W-1:0] tick_sum;
    logic [SUM_W-1:0] tick_top;
    logic             do_chan;
    logic [6:0]       chan_d2;
    logic             evt_valid;
    mtep_pkg::t_event evt;

    function automatic logic meta_known(input logic [7:0] t);
        return (t <= 8'h09) || (t == 8'h20) || (t == 8'h21) || (t == 8'h2F) ||
               (t == 8'h4B) || (t == 8'h51) || (t == 8'h54) || (t == 8'h58) ||
               (t == 8'h59) || (t == 8'h7F);
    endfunction

    always_comb begin
        // a track start wipes the state before the byte is parsed
        c_phase  = i_start ? PH_DELTA : r_phase;
        c_status = i_start ? 8'd0 : r_status;
        c_tick   = i_start ? '0 : r_tick;
        c_acc    = i_start ? 32'd0 : r_acc;
        c_left   = i_start ? 32'd0 : r_left;
        c_held   = i_start ? 7'd0 : r_held;
        c_meta   = i_start ? 8'd0 : r_meta;
        c_tempo  = i_start ? 24'd0 : r_tempo;
        c_halted = i_start ? 1'b0 : r_halted;

        n_phase  = c_phase;
        n_status = c_status;
        n_tick   = c_tick;
        n_acc    = c_acc;
        n_left   = c_left;
        n_held   = c_held;
        n_meta   = c_meta;
        n_tempo  = c_tempo;
        n_halted = c_halted;

        vlq      = {c_acc[24:0], i_byte[6:0]};
        left_dec = (c_left != 32'd0) ? (c_left - 32'd1) : 32'd0;
        tick_ext = SUM_W'(c_tick);
        tick_sum = tick_ext + SUM_W'(vlq);
        tick_top = SUM_W'({TICK_BITS{1'b1}});
        do_chan  = 1'b0;
        chan_d2  = 7'd0;

        evt_valid        = 1'b0;
        evt.kind         = 4'd0;
        evt.channel      = 4'd0;
        evt.first_value  = 7'd0;
        evt.second_value = 24'd0;
        evt.tick         = tick_ext[31:0];

        if (!c_halted) begin
            case (c_phase)
                PH_STATUS: begin
                    if (i_byte[7]) begin
                        if (i_byte < ST_SYSTEM) begin
                            n_status = i_byte;
                            n_phase  = PH_DATA1;
                        end else begin
                            n_status = 8'd0;
                            n_acc    = 32'd0;
                            if (i_byte == ST_META) begin
                                n_phase = PH_METATYPE;
                            end else if (i_byte == ST_SYSEX || i_byte == ST_ESCAPE) begin
                                n_phase = PH_SYSLEN;
                            end else begin
                                n_left  = 32'd1;
                                n_phase = PH_SKIP;
                            end
                        end
                    end else if (c_status == 8'd0) begin
                        n_halted  = 1'b1;
                        evt_valid = 1'b1;
                        evt.kind  = mtep_pkg::KIND_ERROR;
                    end else begin
                        n_held = i_byte[6:0];
                        if (c_status[7:5] == 3'b110) begin
                            do_chan = 1'b1;
                        end else begin
                            n_phase = PH_DATA2;
                        end
                    end
                end
                PH_DATA1: begin
                    n_held = i_byte[6:0];
                    if (c_status[7:5] == 3'b110) begin
                        do_chan = 1'b1;
                    end else begin
                        n_phase = PH_DATA2;
                    end
                end
                PH_DATA2: begin
                    do_chan = 1'b1;
                    chan_d2 = i_byte[6:0];
                end
                PH_SYSLEN: begin
                    n_acc = vlq;
                    if (!i_byte[7]) begin
                        n_left  = vlq;
                        n_phase = (vlq != 32'd0) ? PH_SKIP : PH_DELTA;
                    end
                end
                PH_SKIP: begin
                    n_left = left_dec;
                    if (left_dec == 32'd0) begin
                        n_phase = PH_DELTA;
                    end
                end
                PH_METATYPE: begin
                    n_meta = i_byte;
                    if (!meta_known(i_byte)) begin
                        n_halted  = 1'b1;
                        evt_valid = 1'b1;
                        evt.kind  = mtep_pkg::KIND_ERROR;
                    end else begin
                        n_acc   = 32'd0;
                        n_phase = PH_METALEN;
                    end
                end
                PH_METALEN: begin
                    n_acc = vlq;
                    if (!i_byte[7]) begin
                        if (c_meta == META_END) begin
                            n_halted  = 1'b1;
                            evt_valid = 1'b1;
                            if (vlq != 32'd0) begin
                                evt.kind = mtep_pkg::KIND_ERROR;
                            end else begin
                                n_phase  = PH_DELTA;
                                evt.kind = mtep_pkg::KIND_END;
                            end
                        end else if (c_meta == META_TEMPO) begin
                            if (vlq != 32'd3) begin
                                n_halted  = 1'b1;
                                evt_valid = 1'b1;
                                evt.kind  = mtep_pkg::KIND_ERROR;
                            end else begin
                                n_left  = 32'd3;
                                n_tempo = 24'd0;
                                n_phase = PH_TEMPO;
                            end
                        end else begin
                            n_left  = vlq;
                            n_phase = (vlq != 32'd0) ? PH_SKIP : PH_DELTA;
                        end
                    end
                end
                PH_TEMPO: begin
                    n_tempo = {c_tempo[15:0], i_byte};
                    n_left  = left_dec;
                    if (left_dec == 32'd0) begin
                        n_phase          = PH_DELTA;
                        evt_valid        = 1'b1;
                        evt.kind         = mtep_pkg::KIND_TEMPO;
                        evt.second_value = {c_tempo[15:0], i_byte};
                    end
                end
                default: begin
                    n_acc = vlq;
                    if (!i_byte[7]) begin
                        // clamp the running tick at its top value
                        n_tick  = (tick_sum > tick_top) ? {TICK_BITS{1'b1}}
                                                        : tick_sum[TICK_BITS-1:0];
                        n_acc   = 32'd0;
                        n_phase = PH_STATUS;
                    end
                end
            endcase
        end

        if (do_chan) begin
            n_phase     = PH_DELTA;
            evt_valid   = 1'b1;
            evt.kind    = {1'b0, c_status[6:4]};
            evt.channel = c_status[3:0];
            case (c_status[6:4])
                3'd4, 3'd5: begin
                    evt.first_value = n_held;
                end
                3'd6: begin
                    evt.second_value = {10'd0, chan_d2, n_held};
                end
                default: begin
                    evt.first_value  = n_held;
                    evt.second_value = {17'd0, chan_d2};
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_DELTA;
            r_status <= 8'd0;
            r_tick   <= '0;
            r_acc    <= 32'd0;
            r_left   <= 32'd0;
            r_held   <= 7'd0;
            r_meta   <= 8'd0;
            r_tempo  <= 24'd0;
            r_halted <= 1'b0;
        end else if (i_valid) begin
            r_phase  <= n_phase;
            r_status <= n_status;
            r_tick   <= n_tick;
            r_acc    <= n_acc;
            r_left   <= n_left;
            r_held   <= n_held;
            r_meta   <= n_meta;
            r_tempo  <= n_tempo;
            r_halted <= n_halted;
        end
    end

    assign o_evt_valid = evt_valid;
    assign o_evt       = evt;

    a_halt_after_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && evt_valid &&
         (evt.kind == mtep_pkg::KIND_END || evt.kind == mtep_pkg::KIND_ERROR))
        |=> r_halted)
        else $error("parser did not halt after end or error");

    a_halted_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_halted && !i_start) |-> !evt_valid)
        else $error("event produced while halted");

    a_start_clears_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_start) |=> !r_halted)
        else $error("track start did not clear the halt");

endmodule

// File: design/midi_track_event_parser.sv
// MIDI track event parser.
// Slave side: one track byte per item on s_axis_tdata; s_axis_tuser is set on
// the first byte of a new track and clears the tick count, running status and
// halt before that byte is parsed.
// Master side: one item per recognized event (channel message, tempo, end of
// track or error); tuser carries the event kind, tdata its channel, values and
// absolute tick. Bytes that complete no event give no output item.
// Throughput: one byte per cycle while the skid register is empty. Each byte
// is held in the input register, parsed by combinational logic, and its
// event lands in the output register, from which the master side shows it.
// A stalled receiver is absorbed by a one-entry skid register behind the
// output register; parsing holds while the skid is full, and input stops once
// the input register also holds a byte.
// Reset (synchronous, active low) empties all stages and restarts parsing
// at a delta time with no running status and tick zero.
// After end of track or an error the parser drops bytes until a track start.
module midi_track_event_parser #(
    parameter int TICK_BITS = mtep_pkg::TICK_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [mtep_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // [7:0] byte_in
    input  logic [mtep_pkg::IN_USER_W-1:0]  s_axis_tuser,  // [0] track_start
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [3:0] channel, [10:4] first_value, [34:11] second_value,
    // [66:35] event_tick, [71:67] zero
    output logic [mtep_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic [mtep_pkg::OUT_USER_W-1:0] m_axis_tuser   // [3:0] event_kind
);

    logic             r_in_valid, n_in_valid;
    logic [7:0]       r_byte;
    logic             r_start;
    logic             r_out_valid, n_out_valid;
    mtep_pkg::t_event r_out, n_out;
    logic             r_skid_valid, n_skid_valid;
    mtep_pkg::t_event r_skid, n_skid;

    logic             advance;
    logic             core_valid;
    mtep_pkg::t_event core_evt;

    assign advance       = r_in_valid && !r_skid_valid;
    assign s_axis_tready = !r_in_valid || advance;

    mtep_core #(
        .TICK_BITS (TICK_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (advance),
        .i_byte      (r_byte),
        .i_start     (r_start),
        .o_evt_valid (core_valid),
        .o_evt       (core_evt)
    );

    always_comb begin
        n_in_valid   = s_axis_tready ? s_axis_tvalid : r_in_valid;
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (!r_out_valid || m_axis_tready) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = core_evt;
                n_out_valid = advance && core_valid;
            end
        end else if (advance && core_valid) begin
            // output stalled: park the new event
            n_skid       = core_evt;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_in_valid   <= n_in_valid;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready) begin
            r_byte  <= s_axis_tdata;
            r_start <= s_axis_tuser[0];
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = {5'd0, r_out.tick, r_out.second_value,
                            r_out.first_value, r_out.channel};

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds an event while output is empty");

    a_skid_blocks_parse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !advance)
        else $error("parser advanced with a full skid");

    a_skid_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready && advance && core_valid) |=> r_skid_valid)
        else $error("event lost while output stalled");

endmodule

// File: tb/testbench.sv
module testbench;

    // status nibbles of the channel messages
    localparam logic [3:0] NIB_NOTE_OFF      = 4'h8;
    localparam logic [3:0] NIB_NOTE_ON       = 4'h9;
    localparam logic [3:0] NIB_KEY_PRESSURE  = 4'hA;
    localparam logic [3:0] NIB_CONTROL       = 4'hB;
    localparam logic [3:0] NIB_PROGRAM       = 4'hC;
    localparam logic [3:0] NIB_CHAN_PRESSURE = 4'hD;
    localparam logic [3:0] NIB_PITCH         = 4'hE;

    localparam logic [3:0] KIND_PROGRAM       = 4'd4;
    localparam logic [3:0] KIND_CHAN_PRESSURE = 4'd5;
    localparam logic [3:0] KIND_PITCH         = 4'd6;

    localparam logic [7:0] CHAN_LOWEST    = 8'h80;
    localparam logic [7:0] CHAN_HIGHEST   = 8'hEF;
    localparam logic [7:0] SYS_SYSEX      = 8'hF0;
    localparam logic [7:0] SYS_SYSEX_CONT = 8'hF7;
    localparam logic [7:0] SYS_UNDEF_LOW  = 8'hF1;
    localparam logic [7:0] SYS_UNDEF_HIGH = 8'hFE;
    localparam logic [7:0] SYS_META       = 8'hFF;

    localparam logic [7:0] META_TEXT_LAST = 8'h09;
    localparam logic [7:0] META_END       = 8'h2F;
    localparam logic [7:0] META_TEMPO     = 8'h51;
    localparam logic [7:0] META_LISTED [9] = '{8'h20, 8'h21, 8'h2F, 8'h4B, 8'h51,
                                               8'h54, 8'h58, 8'h59, 8'h7F};

    localparam int RANDOM_ITEMS = 1000;
    localparam int MAX_SHOWN    = 10;

    typedef enum logic [3:0] {
        AT_DELTA, AT_STATUS, AT_DATA1, AT_DATA2, AT_SYSEX_LEN, AT_SKIP,
        AT_META_TYPE, AT_META_LEN, AT_TEMPO
    } t_parse_phase;

    class event_scoreboard;
        mtep_pkg::t_event expected_q[$];
        int               fails;
        int               live_items;
        t_parse_phase     phase;
        logic [7:0]       status;
        logic [31:0]      tick;
        logic [31:0]      vlq;
        logic [31:0]      remaining;
        logic [6:0]       held;
        logic [7:0]       meta_type;
        logic [23:0]      tempo;
        bit               halted;

        function new();
            fails      = 0;
            live_items = 0;
            clear();
        endfunction

        static function bit known_meta(logic [7:0] t);
            if (t <= META_TEXT_LAST)
                return 1'b1;
            foreach (META_LISTED[i])
                if (META_LISTED[i] == t)
                    return 1'b1;
            return 1'b0;
        endfunction

        function void clear();
            phase     = AT_DELTA;
            status    = '0;
            tick      = '0;
            vlq       = '0;
            remaining = '0;
            held      = '0;
            meta_type = '0;
            tempo     = '0;
            halted    = 1'b0;
        endfunction

        function void push_result(logic [3:0] kind, logic [3:0] chan, logic [6:0] v1,
                                  logic [23:0] v2);
            mtep_pkg::t_event ev;
            ev.kind         = kind;
            ev.channel      = chan;
            ev.first_value  = v1;
            ev.second_value = v2;
            ev.tick         = tick;
            expected_q.insert(expected_q.size(), ev);
        endfunction

        function void raise_error();
            halted = 1'b1;
            push_result(mtep_pkg::KIND_ERROR, '0, '0, '0);
        endfunction

        function void finish_channel(logic [6:0] d2);
            logic [3:0] kind;
            kind  = {1'b0, status[6:4]};
            phase = AT_DELTA;
            if (kind == KIND_PROGRAM || kind == KIND_CHAN_PRESSURE)
                push_result(kind, status[3:0], held, '0);
            else if (kind == KIND_PITCH)
                push_result(kind, status[3:0], '0, {10'd0, d2, held});
            else
                push_result(kind, status[3:0], held, {17'd0, d2});
        endfunction

        function void first_data(logic [7:0] b);
            held = b[6:0];
            if (status[7:4] == NIB_PROGRAM || status[7:4] == NIB_CHAN_PRESSURE)
                finish_channel('0);
            else
                phase = AT_DATA2;
        endfunction

        // advance the parser by one accepted item
        function void note_item(logic [7:0] b, logic track_start);
            logic [32:0] sum;
            bit          term;
            term = !b[7];
            if (track_start)
                clear();
            if (halted)
                return;
            live_items++;
            case (phase)
                AT_STATUS: begin
                    if (b[7]) begin
                        if (b < SYS_SYSEX) begin
                            status = b;
                            phase  = AT_DATA1;
                        end else begin
                            status = '0;
                            vlq    = '0;
                            if (b == SYS_META) begin
                                phase = AT_META_TYPE;
                            end else if (b == SYS_SYSEX || b == SYS_SYSEX_CONT) begin
                                phase = AT_SYSEX_LEN;
                            end else begin
                                remaining = 1;
                                phase     = AT_SKIP;
                            end
                        end
                    end else if (status == '0) begin
                        raise_error();
                    end else begin
                        first_data(b);
                    end
                end
                AT_DATA1: first_data(b);
                AT_DATA2: finish_channel(b[6:0]);
                AT_SYSEX_LEN: begin
                    vlq = {vlq[24:0], b[6:0]};
                    if (term) begin
                        remaining = vlq;
                        phase     = (vlq != 0) ? AT_SKIP : AT_DELTA;
                    end
                end
                AT_SKIP: begin
                    if (remaining != 0)
                        remaining--;
                    if (remaining == 0)
                        phase = AT_DELTA;
                end
                AT_META_TYPE: begin
                    meta_type = b;
                    if (!known_meta(b)) begin
                        raise_error();
                    end else begin
                        vlq   = '0;
                        phase = AT_META_LEN;
                    end
                end
                AT_META_LEN: begin
                    vlq = {vlq[24:0], b[6:0]};
                    if (term) begin
                        if (meta_type == META_END) begin
                            if (vlq != 0) begin
                                raise_error();
                            end else begin
                                halted = 1'b1;
                                phase  = AT_DELTA;
                                push_result(mtep_pkg::KIND_END, '0, '0, '0);
                            end
                        end else if (meta_type == META_TEMPO) begin
                            if (vlq != 3) begin
                                raise_error();
                            end else begin
                                remaining = 3;
                                tempo     = '0;
                                phase     = AT_TEMPO;
                            end
                        end else begin
                            remaining = vlq;
                            phase     = (vlq != 0) ? AT_SKIP : AT_DELTA;
                        end
                    end
                end
                AT_TEMPO: begin
                    tempo = {tempo[15:0], b};
                    if (remaining != 0)
                        remaining--;
                    if (remaining == 0) begin
                        phase = AT_DELTA;
                        push_result(mtep_pkg::KIND_TEMPO, '0, '0, tempo);
                    end
                end
                default: begin
                    vlq = {vlq[24:0], b[6:0]};
                    if (term) begin
                        // clamp the tick at its top value
                        sum   = {1'b0, tick} + {1'b0, vlq};
                        tick  = sum[32] ? '1 : sum[31:0];
                        vlq   = '0;
                        phase = AT_STATUS;
                    end
                end
            endcase
        endfunction

        function void check_result(mtep_pkg::t_event got);
            mtep_pkg::t_event exp;
            if (expected_q.size() == 0) begin
                fails++;
                if (fails <= MAX_SHOWN)
                    $display("unexpected event: kind %0d ch %0d v1 %0d v2 %0h tick %0h",
                             got.kind, got.channel, got.first_value, got.second_value,
                             got.tick);
                return;
            end
            exp = expected_q.pop_front();
            if (got.kind !== exp.kind || got.channel !== exp.channel ||
                got.first_value !== exp.first_value ||
                got.second_value !== exp.second_value || got.tick !== exp.tick) begin
                fails++;
                if (fails <= MAX_SHOWN)
                    $display("event mismatch: expected kind %0d ch %0d v1 %0d v2 %0h",
                             exp.kind, exp.channel, exp.first_value, exp.second_value,
                             " tick %0h, got kind %0d ch %0d v1 %0d v2 %0h tick %0h",
                             exp.tick, got.kind, got.channel, got.first_value,
                             got.second_value, got.tick);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] byte_in
    logic [0:0]  s_axis_tuser;   // [0] track_start
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;   // [3:0] channel, [10:4] first_value,
                                 // [34:11] second_value, [66:35] event_tick
    logic [3:0]  m_axis_tuser;   // [3:0] event_kind

    event_scoreboard  sb = new();
    mtep_pkg::t_event seen_event;
    bit               idle_on = 1'b1;
    bit               gen_rs;
    bit               gen_halted;
    logic [7:0]       gen_status;

    midi_track_event_parser u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #3000000;
        $display("FAILURE");
        $finish;
    end

    // receiver stalls in random bursts
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (idle_on && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 6) - 1) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_event.kind         = m_axis_tuser;
            seen_event.channel      = m_axis_tdata[3:0];
            seen_event.first_value  = m_axis_tdata[10:4];
            seen_event.second_value = m_axis_tdata[34:11];
            seen_event.tick         = m_axis_tdata[66:35];
            sb.check_result(seen_event);
        end
    end

    // entered and left at a falling edge
    task automatic send_item(input logic [7:0] b, input logic st);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= st;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(b, st);
        @(negedge i_clk);
    endtask

    task automatic send_seq(input logic [7:0] seq[$], input logic st);
        foreach (seq[i])
            send_item(seq[i], st && i == 0);
    endtask

    // variable-length field, optionally padded with leading zero groups
    task automatic send_vlq(input logic [31:0] val, input int pad, input logic st);
        int n;
        n = 1;
        while (n < 5 && (val >> (7 * n)) != 0)
            n++;
        for (int i = n + pad - 1; i >= 0; i--)
            send_item({i != 0, 7'(val >> (7 * i))}, st && i == n + pad - 1);
    endtask

    function automatic logic [7:0] rand_data();
        return ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 127));
    endfunction

    function automatic int rand_pad();
        return ($urandom_range(0, 3) == 0) ? 1 : 0;
    endfunction

    task automatic send_delta(input logic st);
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            send_vlq($urandom_range(0, 127), rand_pad(), st);
        end else if (pick < 85) begin
            send_vlq($urandom_range(0, 16383), rand_pad(), st);
        end else if (pick < 95) begin
            send_vlq($urandom_range(0, 2097151), rand_pad(), st);
        end else begin
            // long raw field: upper groups wrap out of the count
            n = $urandom_range(5, 6);
            for (int i = 0; i < n; i++)
                send_item({i != n - 1, 7'($urandom)}, st && i == 0);
        end
    endtask

    task automatic send_event(input logic st);
        int         pick;
        int         n;
        logic [7:0] b;
        send_delta(st);
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            if (!gen_rs || $urandom_range(0, 2) == 0) begin
                gen_status = 8'($urandom_range(CHAN_LOWEST, CHAN_HIGHEST));
                gen_rs     = 1'b1;
                send_item(gen_status, 1'b0);
                send_item(rand_data(), 1'b0);
            end else begin
                send_item(8'($urandom_range(0, 127)), 1'b0);
            end
            if (gen_status[7:4] != NIB_PROGRAM && gen_status[7:4] != NIB_CHAN_PRESSURE)
                send_item(rand_data(), 1'b0);
        end else if (pick < 70) begin
            gen_rs = 1'b0;
            send_item(SYS_META, 1'b0);
            send_item(META_TEMPO, 1'b0);
            send_vlq(3, rand_pad(), 1'b0);
            repeat (3) send_item(8'($urandom), 1'b0);
        end else if (pick < 80) begin
            gen_rs = 1'b0;
            if ($urandom_range(0, 1) == 0)
                b = 8'($urandom_range(0, META_TEXT_LAST));
            else
                do b = META_LISTED[$urandom_range(0, 8)];
                while (b == META_END || b == META_TEMPO);
            n = $urandom_range(0, 6);
            send_item(SYS_META, 1'b0);
            send_item(b, 1'b0);
            send_vlq(n, rand_pad(), 1'b0);
            repeat (n) send_item(8'($urandom), 1'b0);
        end else if (pick < 88) begin
            gen_rs = 1'b0;
            n = $urandom_range(0, 6);
            send_item(($urandom_range(0, 1) == 0) ? SYS_SYSEX : SYS_SYSEX_CONT, 1'b0);
            send_vlq(n, rand_pad(), 1'b0);
            repeat (n) send_item(8'($urandom), 1'b0);
        end else if (pick < 94) begin
            gen_rs = 1'b0;
            do b = 8'($urandom_range(SYS_UNDEF_LOW, SYS_UNDEF_HIGH));
            while (b == SYS_SYSEX_CONT);
            send_item(b, 1'b0);
            send_item(8'($urandom), 1'b0);
        end else if (pick < 98) begin
            repeat ($urandom_range(1, 3)) send_item(8'($urandom), 1'b0);
        end else begin
            case ($urandom_range(0, 3))
                0: begin
                    // data byte after running status was cancelled
                    send_item(SYS_UNDEF_LOW, 1'b0);
                    send_item(8'($urandom), 1'b0);
                    send_delta(1'b0);
                    send_item(8'($urandom_range(0, 127)), 1'b0);
                end
                1: begin
                    do b = 8'($urandom);
                    while (event_scoreboard::known_meta(b));
                    send_item(SYS_META, 1'b0);
                    send_item(b, 1'b0);
                end
                2: begin
                    do n = $urandom_range(0, 10);
                    while (n == 3);
                    send_item(SYS_META, 1'b0);
                    send_item(META_TEMPO, 1'b0);
                    send_vlq(n, rand_pad(), 1'b0);
                end
                default: begin
                    send_item(SYS_META, 1'b0);
                    send_item(META_END, 1'b0);
                    send_vlq($urandom_range(1, 200), rand_pad(), 1'b0);
                end
            endcase
            gen_halted = 1'b1;
            repeat ($urandom_range(0, 2)) send_item(8'($urandom), 1'b0);
        end
    endtask

    initial begin
        int n_events;
        bit drained;
        drained       = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // every channel kind, running status, top bit in data, zero velocity
        send_seq('{8'h00, {NIB_NOTE_OFF, 4'h0}, 8'h00, 8'h00}, 1'b1);
        send_seq('{8'h00, {NIB_NOTE_ON, 4'hF}, 8'h7F, 8'hFF}, 1'b0);
        send_seq('{8'h00, 8'h00, 8'h00}, 1'b0);
        send_seq('{8'h81, 8'h00, {NIB_KEY_PRESSURE, 4'h5}, 8'h40, 8'h20}, 1'b0);
        send_seq('{8'h00, {NIB_CONTROL, 4'h3}, 8'h07, 8'h64}, 1'b0);
        send_seq('{8'h00, {NIB_PROGRAM, 4'h7}, 8'hFF}, 1'b0);
        send_seq('{8'h00, {NIB_CHAN_PRESSURE, 4'h0}, 8'h55}, 1'b0);
        send_seq('{8'h00, {NIB_PITCH, 4'h9}, 8'h7F, 8'h7F}, 1'b0);
        // largest tempo with a padded length
        send_seq('{8'h00, SYS_META, META_TEMPO, 8'h80, 8'h03, 8'hFF, 8'hFF, 8'hFF}, 1'b0);
        send_seq('{8'h00, SYS_SYSEX, 8'h02, 8'h11, SYS_SYSEX_CONT}, 1'b0);
        send_seq('{8'h00, SYS_UNDEF_HIGH, 8'h05}, 1'b0);
        // data with no running status, then a byte dropped while halted
        send_seq('{8'h00, 8'h40, 8'h00}, 1'b0);
        // wrapped delta to the top tick, then saturation
        send_seq('{8'h8F, 8'hFF, 8'hFF, 8'hFF, 8'h7F, {NIB_PROGRAM, 4'h0}, 8'h00}, 1'b1);
        send_seq('{8'h01, {NIB_PROGRAM, 4'h1}, 8'h01}, 1'b0);
        send_seq('{8'h00, SYS_META, META_TEXT_LAST, 8'h02, 8'h41, 8'h42}, 1'b0);
        send_seq('{8'h00, SYS_META, 8'h30}, 1'b0);
        send_seq('{8'h00, SYS_META, META_TEMPO, 8'h02}, 1'b1);
        send_seq('{8'h00, SYS_META, META_END, 8'h01}, 1'b1);
        send_seq('{8'h00, SYS_META, META_END, 8'h00}, 1'b1);

        while (sb.live_items < RANDOM_ITEMS) begin
            gen_rs     = 1'b0;
            gen_halted = 1'b0;
            n_events   = $urandom_range(1, 30);
            for (int i = 0; i < n_events && !gen_halted; i++)
                send_event(i == 0);
            if (!gen_halted && $urandom_range(0, 3) != 0) begin
                send_delta(1'b0);
                send_item(SYS_META, 1'b0);
                send_item(META_END, 1'b0);
                send_vlq(0, rand_pad(), 1'b0);
                repeat ($urandom_range(0, 1)) send_item(8'($urandom), 1'b0);
            end
            if (!drained && sb.live_items >= RANDOM_ITEMS / 2) begin
                // hold input until every event is out
                s_axis_tvalid <= 1'b0;
                do @(negedge i_clk); while (sb.pending() != 0);
                drained = 1'b1;
            end
            if (sb.live_items >= RANDOM_ITEMS * 85 / 100)
                idle_on = 1'b0;
        end

        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.fails == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
